@@ src/u64au_pkg.sv @@
// Types and codes shared by the 64-bit arithmetic unit.
// Holds the request and response beat formats and the per-stage pipeline word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package u64au_pkg;
   localparam int WORD_BITS = 64;
   localparam int HALF_BITS = WORD_BITS / 2;
   localparam int DIV_STEPS = WORD_BITS;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   localparam logic [1:0] CMP_LESS    = 2'd0;
   localparam logic [1:0] CMP_EQUAL   = 2'd1;
   localparam logic [1:0] CMP_GREATER = 2'd2;

   typedef struct packed {
      logic [2:0]           op;
      logic [WORD_BITS-1:0] operand_a;
      logic [WORD_BITS-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] result_value;
      logic [WORD_BITS-1:0] remainder_value;
      logic [1:0]           compare_code;
   } rsp_type;

   typedef struct packed {
      logic [2:0]           op;
      logic [WORD_BITS-1:0] res;
      logic [WORD_BITS-1:0] rem;
      logic [WORD_BITS-1:0] divisor;
      logic [1:0]           code;
   } stage_type;
endpackage
`default_nettype wire

@@ src/u64au_div_stage.sv @@
// One restoring-division step with its pipeline register; other ops pass through.
// Depends on u64au_pkg for the stage word and operation codes.
`timescale 1ns / 1ps
`default_nettype none
module u64au_div_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire u64au_pkg::stage_type in_stage,
   input  wire logic                 hold,
   output logic                      out_valid,
   output u64au_pkg::stage_type      out_stage
);
   logic                 valid_ff;
   u64au_pkg::stage_type stage_ff;
   u64au_pkg::stage_type stage_in;
   logic [u64au_pkg::WORD_BITS:0] shifted;
   logic [u64au_pkg::WORD_BITS:0] diff;
   logic                          ge;

   always_comb begin
      shifted  = {in_stage.rem, in_stage.res[u64au_pkg::WORD_BITS-1]};
      diff     = shifted - {1'b0, in_stage.divisor};
      ge       = shifted >= {1'b0, in_stage.divisor};
      stage_in = in_stage;
      if (in_stage.op == u64au_pkg::OP_DIV) begin
         stage_in.res = {in_stage.res[u64au_pkg::WORD_BITS-2:0], ge};
         stage_in.rem = ge ? diff[u64au_pkg::WORD_BITS-1:0]
                           : shifted[u64au_pkg::WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= in_valid;
      end
      if (!hold) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;
endmodule
`default_nettype wire

@@ src/uint64_arithmetic_unit_core.sv @@
// Unsigned 64-bit ALU: add, subtract, low multiply, divide/remainder, compare.
// Every op passes the front register, the divider steps and the output register.
// One beat per cycle when not stalled; the 64 one-bit divider steps set depth.
// Stalls hold only full stages, so bubbles close up behind a waiting response.
// Synchronous reset empties every stage; no other state. Depends on u64au_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uint64_arithmetic_unit_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire u64au_pkg::req_type req_beat,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output u64au_pkg::rsp_type      rsp_beat
);
   localparam int W = u64au_pkg::WORD_BITS;
   localparam int H = u64au_pkg::HALF_BITS;
   localparam int N = u64au_pkg::DIV_STEPS;

   logic                 s1_valid_ff;
   u64au_pkg::req_type   s1_req_ff;
   logic [W-1:0]         s1_pll_ff;
   logic [H-1:0]         s1_plh_ff;
   logic [H-1:0]         s1_phl_ff;
   logic [W-1:0]         pll_in;
   logic [W-1:0]         plh_in;
   logic [W-1:0]         phl_in;
   u64au_pkg::stage_type s2_stage;
   logic [H-1:0]         mid_sum;

   logic                 dv    [N];
   u64au_pkg::stage_type dst   [N];
   logic                 hold  [N+1];
   logic                 s1_hold;

   logic                 out_valid_ff;
   u64au_pkg::rsp_type   out_beat_ff;
   logic [2:0]           out_op_ff;

   assign hold[N]   = out_valid_ff && rsp_stall;
   assign s1_hold   = s1_valid_ff && hold[0];
   assign req_stall = s1_hold;

   always_comb begin
      pll_in = req_beat.operand_a[H-1:0] * req_beat.operand_b[H-1:0];
      plh_in = req_beat.operand_a[H-1:0] * req_beat.operand_b[W-1:H];
      phl_in = req_beat.operand_a[W-1:H] * req_beat.operand_b[H-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_hold) begin
         s1_valid_ff <= req_valid;
      end
      if (!s1_hold) begin
         s1_req_ff <= req_beat;
         s1_pll_ff <= pll_in;
         s1_plh_ff <= plh_in[H-1:0];
         s1_phl_ff <= phl_in[H-1:0];
      end
   end

   always_comb begin
      mid_sum          = s1_plh_ff + s1_phl_ff;
      s2_stage.op      = s1_req_ff.op;
      s2_stage.divisor = s1_req_ff.operand_b;
      s2_stage.rem     = '0;
      s2_stage.res     = '0;
      s2_stage.code    = u64au_pkg::CMP_LESS;
      unique case (s1_req_ff.op)
         u64au_pkg::OP_ADD: begin
            s2_stage.res = s1_req_ff.operand_a + s1_req_ff.operand_b;
         end
         u64au_pkg::OP_SUB: begin
            s2_stage.res = s1_req_ff.operand_a - s1_req_ff.operand_b;
         end
         u64au_pkg::OP_MUL: begin
            s2_stage.res = s1_pll_ff + {mid_sum, {H{1'b0}}};
         end
         u64au_pkg::OP_DIV: begin
            s2_stage.res = s1_req_ff.operand_a;
         end
         u64au_pkg::OP_CMP: begin
            if (s1_req_ff.operand_a < s1_req_ff.operand_b) begin
               s2_stage.code = u64au_pkg::CMP_LESS;
            end else if (s1_req_ff.operand_a == s1_req_ff.operand_b) begin
               s2_stage.code = u64au_pkg::CMP_EQUAL;
            end else begin
               s2_stage.code = u64au_pkg::CMP_GREATER;
            end
         end
         default: begin
            s2_stage.res = '0;
         end
      endcase
   end

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_div
         assign hold[k] = dv[k] && hold[k+1];
         if (k == 0) begin : g_first
            u64au_div_stage u_step (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (s1_valid_ff),
               .in_stage  (s2_stage),
               .hold      (hold[k]),
               .out_valid (dv[k]),
               .out_stage (dst[k])
            );
         end else begin : g_rest
            u64au_div_stage u_step (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (dv[k-1]),
               .in_stage  (dst[k-1]),
               .hold      (hold[k]),
               .out_valid (dv[k]),
               .out_stage (dst[k])
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!hold[N]) begin
         out_valid_ff <= dv[N-1];
      end
      if (!hold[N]) begin
         out_beat_ff.result_value    <= dst[N-1].res;
         out_beat_ff.remainder_value <= dst[N-1].rem;
         out_beat_ff.compare_code    <= dst[N-1].code;
         out_op_ff                   <= dst[N-1].op;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

`ifndef SYNTHESIS
   a_rem_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_op_ff != u64au_pkg::OP_DIV |-> out_beat_ff.remainder_value == '0)
      else $error("remainder set on a non-divide beat");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && dv[0])
      else $error("request stalled while front stage can advance");
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall && dv[N-1] |=> dv[N-1] && $stable(dst[N-1]))
      else $error("last divider stage lost a beat under stall");
`endif
endmodule
`default_nettype wire
